### rtl/vt_pkg.sv
// Shared types, constants and command/status structs for the VT100 parser.
package vt_pkg;

  localparam int MAX_PARAMS_DEF = 16;
  localparam int RESULT_CAP     = 16;
  localparam int BYTE_W         = 8;
  localparam int ACT_W          = 4;
  localparam int IDX_W          = 4;
  localparam int VAL_W          = 15;
  localparam int ACC_W          = 18;   // holds 16383*10+9

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1b;
  localparam logic [BYTE_W-1:0] TN_IAC   = 8'd255;
  localparam logic [BYTE_W-1:0] TN_SB    = 8'd250;
  localparam logic [BYTE_W-1:0] TN_SE    = 8'd240;
  localparam logic [BYTE_W-1:0] CH_BEL   = 8'h07;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0b;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5b;  // '['
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [BYTE_W-1:0] CH_LPAR  = 8'h28;  // '('
  localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;  // ')'
  localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3f;  // '?'
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;  // ';'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_EIGHT = 8'h38;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TOP   = 8'd127;

  localparam logic signed [VAL_W-1:0] PARAM_DEFAULT = -15'sd1;
  localparam logic signed [VAL_W-1:0] PARAM_QMARK   = -15'sd2;
  localparam logic signed [VAL_W-1:0] PARAM_SAT     = 15'sd16383;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRINT = 4'd0,
    ACT_BELL  = 4'd1,
    ACT_BS    = 4'd2,
    ACT_TAB   = 4'd3,
    ACT_LF    = 4'd4,
    ACT_CR    = 4'd5,
    ACT_ESC   = 4'd6,
    ACT_CSI   = 4'd7,
    ACT_ALIGN = 4'd8
  } action_t;

  typedef enum logic [3:0] {
    PS_GROUND = 4'd0,
    PS_ESC    = 4'd1,
    PS_CSI    = 4'd2,
    PS_HASH   = 4'd3,
    PS_LPAREN = 4'd4,
    PS_RPAREN = 4'd5,
    PS_IAC    = 4'd6,
    PS_SB     = 4'd7,
    PS_SB_IAC = 4'd8,
    PS_OPT    = 4'd9
  } parse_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ESC2,
    CS_EMIT_RD,
    CS_EMIT_LD
  } seq_t;

  typedef enum logic [1:0] {
    CH_IN,
    CH_ESC,
    CH_HELD
  } char_sel_t;

  typedef struct packed {
    logic bs;
    logic esc;
    logic iac;
    logic sb;
    logic se;
    logic lbrack;
    logic hash;
    logic lparen;
    logic rparen;
    logic esc_final;
    logic digit;
    logic qmark;
    logic semi;
    logic eight;
    logic printable;
    logic bel;
    logic ht;
    logic lf;
    logic cr;
  } byte_flags_t;

  typedef struct packed {
    byte_flags_t flags;
    logic        out_free;
    logic        emit_done;
  } dp_stat_t;

  typedef struct packed {
    logic      take_byte;
    logic      clear_params;
    logic      acc_digit;
    logic      qmark;
    logic      semi;
    logic      emit_start;
    logic      emit_read;
    logic      emit_load;
    logic      out_load;
    action_t   out_act;
    char_sel_t out_char;
    logic      out_last;
  } dp_cmd_t;

endpackage

### rtl/vt_if.sv
// Handshake channel interfaces for host bytes and parser results.
interface vt_in_if;
  logic                         valid;
  logic                         ready;
  logic [vt_pkg::BYTE_W-1:0]    in_byte;
  logic                         chunk_end;
  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface vt_out_if;
  logic                             valid;
  logic                             ready;
  logic [vt_pkg::ACT_W-1:0]         action;
  logic [vt_pkg::BYTE_W-1:0]        char_code;
  logic [vt_pkg::IDX_W-1:0]         param_index;
  logic signed [vt_pkg::VAL_W-1:0]  param_value;
  logic                             last;
  modport source (output valid, output action, output char_code, output param_index,
                  output param_value, output last, input ready);
  modport sink (input valid, input action, input char_code, input param_index,
                input param_value, input last, output ready);
endinterface

### rtl/vt_ctl.sv
// Parse-state controller and result sequencer for the VT100 parser.
module vt_ctl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vt_pkg::dp_stat_t stat,
  output vt_pkg::dp_cmd_t  cmd
);

  vt_pkg::parse_t parse, parse_next;
  vt_pkg::seq_t   seq, seq_next;
  logic           accept;

  assign in_ready = (seq == vt_pkg::CS_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse <= vt_pkg::PS_GROUND;
      seq   <= vt_pkg::CS_IDLE;
    end else begin
      parse <= parse_next;
      seq   <= seq_next;
    end
  end

  // next state
  always_comb begin
    parse_next = parse;
    seq_next   = seq;
    case (seq)
      vt_pkg::CS_IDLE: begin
        if (accept) begin
          case (parse)
            vt_pkg::PS_ESC: begin
              if (stat.flags.bs) parse_next = vt_pkg::PS_ESC;
              else if (stat.flags.lbrack) parse_next = vt_pkg::PS_CSI;
              else if (stat.flags.hash) parse_next = vt_pkg::PS_HASH;
              else if (stat.flags.lparen) parse_next = vt_pkg::PS_LPAREN;
              else if (stat.flags.rparen) parse_next = vt_pkg::PS_RPAREN;
              else if (stat.flags.esc_final) parse_next = vt_pkg::PS_GROUND;
              else begin
                parse_next = vt_pkg::PS_GROUND;
                seq_next   = vt_pkg::CS_ESC2;
              end
            end
            vt_pkg::PS_CSI: begin
              if (!(stat.flags.bs || stat.flags.digit || stat.flags.qmark ||
                    stat.flags.semi)) begin
                parse_next = vt_pkg::PS_GROUND;
                seq_next   = vt_pkg::CS_EMIT_RD;
              end
            end
            vt_pkg::PS_HASH, vt_pkg::PS_LPAREN, vt_pkg::PS_RPAREN: begin
              if (!stat.flags.bs) parse_next = vt_pkg::PS_GROUND;
            end
            vt_pkg::PS_IAC: begin
              if (stat.flags.iac) parse_next = vt_pkg::PS_GROUND;
              else if (stat.flags.sb) parse_next = vt_pkg::PS_SB;
              else parse_next = vt_pkg::PS_OPT;
            end
            vt_pkg::PS_SB: begin
              if (stat.flags.iac) parse_next = vt_pkg::PS_SB_IAC;
            end
            vt_pkg::PS_SB_IAC: begin
              if (stat.flags.iac) parse_next = vt_pkg::PS_SB;
              else if (stat.flags.se) parse_next = vt_pkg::PS_GROUND;
            end
            vt_pkg::PS_OPT: parse_next = vt_pkg::PS_GROUND;
            default: begin
              if (stat.flags.esc) parse_next = vt_pkg::PS_ESC;
              else if (stat.flags.iac) parse_next = vt_pkg::PS_IAC;
              else parse_next = vt_pkg::PS_GROUND;
            end
          endcase
        end
      end
      vt_pkg::CS_ESC2: begin
        if (stat.out_free) seq_next = vt_pkg::CS_IDLE;
      end
      vt_pkg::CS_EMIT_RD: seq_next = vt_pkg::CS_EMIT_LD;
      vt_pkg::CS_EMIT_LD: begin
        if (stat.out_free) begin
          seq_next = stat.emit_done ? vt_pkg::CS_IDLE : vt_pkg::CS_EMIT_RD;
        end
      end
      default: seq_next = vt_pkg::CS_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.out_act  = vt_pkg::ACT_PRINT;
    cmd.out_char = vt_pkg::CH_IN;
    cmd.out_last = 1'b1;
    case (seq)
      vt_pkg::CS_IDLE: begin
        if (accept) begin
          cmd.take_byte = 1'b1;
          case (parse)
            vt_pkg::PS_ESC: begin
              if (stat.flags.bs) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_BS;
              end else if (stat.flags.lbrack) begin
                cmd.clear_params = 1'b1;
              end else if (stat.flags.esc_final) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_ESC;
              end else if (!(stat.flags.hash || stat.flags.lparen ||
                             stat.flags.rparen)) begin
                // unknown final: ESC itself goes out first, the byte follows
                cmd.out_load = 1'b1;
                cmd.out_char = vt_pkg::CH_ESC;
                cmd.out_last = 1'b0;
              end
            end
            vt_pkg::PS_CSI: begin
              if (stat.flags.bs) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_BS;
              end else if (stat.flags.digit) begin
                cmd.acc_digit = 1'b1;
              end else if (stat.flags.qmark) begin
                cmd.qmark = 1'b1;
              end else if (stat.flags.semi) begin
                cmd.semi = 1'b1;
              end else begin
                cmd.emit_start = 1'b1;
              end
            end
            vt_pkg::PS_HASH: begin
              if (stat.flags.bs) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_BS;
              end else if (stat.flags.eight) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_ALIGN;
              end
            end
            vt_pkg::PS_LPAREN, vt_pkg::PS_RPAREN: begin
              if (stat.flags.bs) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_BS;
              end
            end
            vt_pkg::PS_IAC, vt_pkg::PS_SB, vt_pkg::PS_SB_IAC, vt_pkg::PS_OPT: begin
              cmd.out_load = 1'b0;
            end
            default: begin
              if (stat.flags.printable) begin
                cmd.out_load = 1'b1;
              end else if (stat.flags.bel) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_BELL;
              end else if (stat.flags.bs) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_BS;
              end else if (stat.flags.ht) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_TAB;
              end else if (stat.flags.lf) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_LF;
              end else if (stat.flags.cr) begin
                cmd.out_load = 1'b1;
                cmd.out_act  = vt_pkg::ACT_CR;
              end
            end
          endcase
        end
      end
      vt_pkg::CS_ESC2: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_char = vt_pkg::CH_HELD;
        end
      end
      vt_pkg::CS_EMIT_RD: cmd.emit_read = 1'b1;
      vt_pkg::CS_EMIT_LD: begin
        if (stat.out_free) cmd.emit_load = 1'b1;
      end
      default: cmd.out_load = 1'b0;
    endcase
  end

endmodule

### rtl/vt_dp.sv
// Datapath: byte decode, CSI parameter store, emit counter and result register.
module vt_dp #(
  parameter int MAX_PARAMS = vt_pkg::MAX_PARAMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [vt_pkg::BYTE_W-1:0]       in_byte,
  input  vt_pkg::dp_cmd_t                 cmd,
  output vt_pkg::dp_stat_t                stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [vt_pkg::ACT_W-1:0]        out_action,
  output logic [vt_pkg::BYTE_W-1:0]       out_char_code,
  output logic [vt_pkg::IDX_W-1:0]        out_param_index,
  output logic signed [vt_pkg::VAL_W-1:0] out_param_value,
  output logic                            out_last
);

  localparam int PW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [PW-1:0] PTR_MAX = PW'(MAX_PARAMS - 1);

  logic [vt_pkg::VAL_W-1:0] mem [MAX_PARAMS];
  logic [MAX_PARAMS-1:0]    pvalid;
  logic [PW-1:0]            ptr;
  logic [PW-1:0]            k;
  logic signed [vt_pkg::VAL_W-1:0] cur;
  logic [vt_pkg::VAL_W-1:0] rd_data;
  logic                     rd_vld;
  logic [vt_pkg::BYTE_W-1:0] held;

  vt_pkg::byte_flags_t      f;
  logic                     out_free;
  logic                     ptr_full;
  logic [vt_pkg::ACC_W-1:0] acc_base;
  logic [vt_pkg::ACC_W-1:0] acc_sum;
  logic signed [vt_pkg::VAL_W-1:0] acc_val;
  logic signed [vt_pkg::VAL_W-1:0] emit_val;
  logic [vt_pkg::BYTE_W-1:0] load_char;

  // byte decode
  always_comb begin
    f           = '0;
    f.bs        = (in_byte == vt_pkg::CH_BS);
    f.esc       = (in_byte == vt_pkg::ESC_BYTE);
    f.iac       = (in_byte == vt_pkg::TN_IAC);
    f.sb        = (in_byte == vt_pkg::TN_SB);
    f.se        = (in_byte == vt_pkg::TN_SE);
    f.lbrack    = (in_byte == vt_pkg::CH_LBRK);
    f.hash      = (in_byte == vt_pkg::CH_HASH);
    f.lparen    = (in_byte == vt_pkg::CH_LPAR);
    f.rparen    = (in_byte == vt_pkg::CH_RPAR);
    f.digit     = (in_byte >= vt_pkg::CH_ZERO) && (in_byte <= vt_pkg::CH_NINE);
    f.qmark     = (in_byte == vt_pkg::CH_QMARK);
    f.semi      = (in_byte == vt_pkg::CH_SEMI);
    f.eight     = (in_byte == vt_pkg::CH_EIGHT);
    f.printable = (in_byte >= vt_pkg::CH_SPACE) && (in_byte <= vt_pkg::CH_TOP);
    f.bel       = (in_byte == vt_pkg::CH_BEL);
    f.ht        = (in_byte == vt_pkg::CH_HT);
    f.lf        = (in_byte == vt_pkg::CH_LF) || (in_byte == vt_pkg::CH_VT) ||
                  (in_byte == vt_pkg::CH_FF);
    f.cr        = (in_byte == vt_pkg::CH_CR);
    case (in_byte)
      8'h3e, 8'h3d, 8'h37, 8'h38, 8'h44, 8'h45, 8'h48, 8'h4d, 8'h5a: f.esc_final = 1'b1;
      default: f.esc_final = 1'b0;
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign ptr_full = (ptr == PTR_MAX);

  assign stat.flags     = f;
  assign stat.out_free  = out_free;
  assign stat.emit_done = (k == ptr) || (int'(k) == vt_pkg::RESULT_CAP - 1);

  // decimal accumulate; a negative entry starts over from zero
  always_comb begin
    acc_base = cur[vt_pkg::VAL_W-1] ? '0 : vt_pkg::ACC_W'($unsigned(cur));
    acc_sum  = acc_base * vt_pkg::ACC_W'(10) + vt_pkg::ACC_W'(in_byte[3:0]);
    if (acc_sum > vt_pkg::ACC_W'($unsigned(vt_pkg::PARAM_SAT))) acc_val = vt_pkg::PARAM_SAT;
    else acc_val = $signed(acc_sum[vt_pkg::VAL_W-1:0]);
  end

  // the entry under the pointer lives in cur, not yet in the store
  always_comb begin
    if (k == ptr) emit_val = cur;
    else if (rd_vld) emit_val = $signed(rd_data);
    else emit_val = vt_pkg::PARAM_DEFAULT;
  end

  always_comb begin
    case (cmd.out_char)
      vt_pkg::CH_ESC:  load_char = vt_pkg::ESC_BYTE;
      vt_pkg::CH_HELD: load_char = held;
      default:         load_char = in_byte;
    endcase
  end

  // parameter store
  always_ff @(posedge clk) begin
    if (cmd.qmark) mem[ptr] <= vt_pkg::PARAM_QMARK;
    else if (cmd.semi) mem[ptr] <= cur;
    if (cmd.emit_read) rd_data <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      ptr    <= '0;
      cur    <= vt_pkg::PARAM_DEFAULT;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.emit_read) rd_vld <= pvalid[k];
      if (cmd.clear_params) begin
        pvalid <= '0;
        ptr    <= '0;
        cur    <= vt_pkg::PARAM_DEFAULT;
      end else if (cmd.acc_digit) begin
        cur <= acc_val;
      end else if (cmd.qmark || cmd.semi) begin
        pvalid[ptr] <= 1'b1;
        if (!ptr_full) begin
          ptr <= ptr + 1'b1;
          cur <= vt_pkg::PARAM_DEFAULT;
        end else if (cmd.qmark) begin
          cur <= vt_pkg::PARAM_QMARK;
        end
      end
    end
  end

  // held byte and emit counter
  always_ff @(posedge clk) begin
    if (cmd.take_byte) held <= in_byte;
    if (cmd.emit_start) k <= '0;
    else if (cmd.emit_load) k <= k + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_action      <= vt_pkg::ACT_CSI;
      out_char_code   <= held;
      out_param_index <= vt_pkg::IDX_W'(k);
      out_param_value <= emit_val;
      out_last        <= stat.emit_done;
    end else if (cmd.out_load) begin
      out_action      <= cmd.out_act;
      out_char_code   <= load_char;
      out_param_index <= '0;
      out_param_value <= '0;
      out_last        <= cmd.out_last;
    end
  end

endmodule

### rtl/vt100_escape_sequence_parser.sv
// Top level of the VT100 escape sequence parser with telnet IAC skipping.
//  channel | modport          | beat
//  host    | vt_in_if.sink    | one received byte (in_byte, chunk_end)
//  result  | vt_out_if.source | action, char_code, param_index, param_value, last
// Control and printable bytes, escape finals: one per cycle unless results stall.
// Unknown ESC final: two beats, ESC and then the held byte once the result is free.
// A CSI final reports min(pointer+1,16) parameters, each in two steps (registered
// store read, then result load); host ready is low until the last one is loaded.
// Reset clears the parse state, the pointer and the store valid bits at once.
// A stalled result is held in the result register; host ready follows it.
module vt100_escape_sequence_parser #(
  parameter int MAX_PARAMS = vt_pkg::MAX_PARAMS_DEF
) (
  input logic      clk,
  input logic      rst,
  vt_in_if.sink    host,
  vt_out_if.source result
);

  vt_pkg::dp_cmd_t  cmd;
  vt_pkg::dp_stat_t stat;

  vt_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (host.valid),
    .in_ready (host.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vt_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_byte         (host.in_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .out_action      (result.action),
    .out_char_code   (result.char_code),
    .out_param_index (result.param_index),
    .out_param_value (result.param_value),
    .out_last        (result.last)
  );

endmodule

### rtl/vt_chk.sv
// Port-level assertion checker for the VT100 parser, bound to the top level.
module vt_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            host_ready,
  input logic                            res_valid,
  input logic [vt_pkg::ACT_W-1:0]        res_action,
  input logic [vt_pkg::BYTE_W-1:0]       res_char_code,
  input logic [vt_pkg::IDX_W-1:0]        res_param_index,
  input logic signed [vt_pkg::VAL_W-1:0] res_param_value,
  input logic                            res_last
);

  // only CSI beats carry a parameter
  a_no_param: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_action != vt_pkg::ACT_CSI) |->
      (res_param_index == '0) && (res_param_value == '0))
    else $error("parameter fields set on a non-CSI beat");

  // only CSI groups and the ESC print of an unknown final span several beats
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_action != vt_pkg::ACT_PRINT) && (res_action != vt_pkg::ACT_CSI)
      |-> res_last)
    else $error("control beat without last");

  a_esc_first: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last && (res_action == vt_pkg::ACT_PRINT) |->
      (res_char_code == vt_pkg::ESC_BYTE))
    else $error("non-last print beat is not ESC");

  // no new byte is taken while a multi-beat group is unfinished
  a_group_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !host_ready)
    else $error("host ready during an unfinished result group");

endmodule

bind vt100_escape_sequence_parser vt_chk u_vt_chk (
  .clk             (clk),
  .rst             (rst),
  .host_ready      (host.ready),
  .res_valid       (result.valid),
  .res_action      (result.action),
  .res_char_code   (result.char_code),
  .res_param_index (result.param_index),
  .res_param_value (result.param_value),
  .res_last        (result.last)
);
